// ===== rtl/ftp_reply_parser_unit_macros.svh =====
// Assertion macros for the FTP reply parser unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FTP_REPLY_PARSER_UNIT_MACROS_SVH
`define FTP_REPLY_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FRP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define FRP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FRP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FRP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/frp_pkg.sv =====
// Shared types, character codes and limits for the FTP reply parser.
// No dependencies; imported by the parser core, the top level, the bench and its checker.
package frp_pkg;

    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_DASH   = 8'h2D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_VT     = 8'h0B;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;

    localparam logic [9:0] CODE_MAX  = 10'd999;
    localparam logic [9:0] CODE_PASV = 10'd227;
    localparam logic [7:0] NUM_MAX   = 8'd255;

    localparam logic [2:0] IDX_LAST   = 3'd5;
    localparam logic [2:0] IDX_DONE   = 3'd6;
    localparam logic [2:0] IDX_FAIL   = 3'd7;
    localparam logic [2:0] ADDR_COUNT = 3'd4;

    typedef enum logic [2:0] {
        MODE_START  = 3'b001,
        MODE_SINGLE = 3'b010,
        MODE_MULTI  = 3'b100
    } t_mode;

    typedef struct packed {
        logic [9:0]  code_acc;
        logic        code_seen;
        logic        code_closed;
        logic        paren_seen;
        logic [2:0]  number_index;
        logic [7:0]  number_acc;
        logic        num_digit;
        logic [31:0] addr_acc;
        logic [15:0] port_acc;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '0;

    typedef struct packed {
        logic [9:0]  reply_code;
        logic        code_present;
        logic        pasv_valid;
        logic [31:0] pasv_addr;
        logic [15:0] pasv_port;
    } t_reply;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_CR) ||
               (b == CHR_LF) || (b == CHR_VT) || (b == CHR_FF);
    endfunction

endpackage

// ===== rtl/frp_byte_if.sv =====
// Valid/ready channel carrying one reply byte per request.
// Depends on nothing beyond the language.
interface frp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/frp_reply_if.sv =====
// Valid/ready channel carrying one parsed reply per request.
// Depends on nothing beyond the language.
interface frp_reply_if;
    logic        valid;
    logic        ready;
    logic [9:0]  reply_code;
    logic        code_present;
    logic        pasv_valid;
    logic [31:0] pasv_addr;
    logic [15:0] pasv_port;

    modport source (output valid, output reply_code, output code_present,
                    output pasv_valid, output pasv_addr, output pasv_port, input ready);
    modport sink (input valid, input reply_code, input code_present,
                  input pasv_valid, input pasv_addr, input pasv_port, output ready);
endinterface

// ===== rtl/frp_core.sv =====
// Parser state and per-byte update: line framing, reply code and address group.
// Depends on frp_pkg.
module frp_core
    import frp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_end,
    output t_reply     o_reply
);

    t_mode       r_mode, n_mode;
    t_parse      r_ps, n_ps;
    t_parse      w_tk;
    logic        w_digit;
    logic [3:0]  w_d;
    logic        w_nonempty;
    logic [13:0] w_code_v;
    logic [11:0] w_num_v;
    logic        w_lf;
    logic        w_pasv;

    assign w_digit    = (i_byte >= CHR_ZERO) && (i_byte <= CHR_NINE);
    assign w_d        = w_digit ? i_byte[3:0] : 4'd0;
    assign w_nonempty = r_ps.code_seen || r_ps.code_closed;
    assign w_lf       = (i_byte == CHR_LF);
    assign w_code_v   = 14'({r_ps.code_acc, 3'b000}) + 14'({r_ps.code_acc, 1'b0}) + 14'(w_d);
    assign w_num_v    = 12'({r_ps.number_acc, 3'b000}) + 12'({r_ps.number_acc, 1'b0}) +
                        12'(w_d);

    always_comb begin
        w_tk = r_ps;
        if (!r_ps.code_closed) begin
            if (w_digit) begin
                w_tk.code_acc  = (w_code_v > 14'(CODE_MAX)) ? CODE_MAX : w_code_v[9:0];
                w_tk.code_seen = 1'b1;
            end else begin
                w_tk.code_closed = 1'b1;
            end
        end
        if (!r_ps.paren_seen) begin
            if (i_byte == CHR_LPAREN) begin
                w_tk.paren_seen   = 1'b1;
                w_tk.number_index = w_nonempty ? 3'd0 : IDX_FAIL;
                w_tk.number_acc   = '0;
                w_tk.num_digit    = 1'b0;
            end
        end else if (r_ps.number_index <= IDX_LAST) begin
            if (w_digit) begin
                w_tk.number_acc = (w_num_v > 12'(NUM_MAX)) ? NUM_MAX : w_num_v[7:0];
                w_tk.num_digit  = 1'b1;
            end else if (!r_ps.num_digit) begin
                if (!is_space(i_byte)) begin
                    w_tk.number_index = IDX_FAIL;
                end
            end else if (r_ps.number_index == IDX_LAST ||  i_byte == CHR_COMMA) begin
                if (r_ps.number_index < ADDR_COUNT) begin
                    w_tk.addr_acc = {r_ps.addr_acc[23:0], r_ps.number_acc};
                end else begin
                    w_tk.port_acc = {r_ps.port_acc[7:0], r_ps.number_acc};
                end
                if (r_ps.number_index == IDX_LAST) begin
                    w_tk.number_index = IDX_DONE;
                end else begin
                    w_tk.number_index = r_ps.number_index + 3'd1;
                    w_tk.number_acc   = '0;
                    w_tk.num_digit    = 1'b0;
                end
            end else begin
                w_tk.number_index = IDX_FAIL;
            end
        end
    end

    assign w_pasv = w_tk.code_seen && (w_tk.code_acc == CODE_PASV) && w_tk.paren_seen &&
                    (w_tk.number_index == IDX_DONE);

    assign o_reply.reply_code   = w_tk.code_seen ? w_tk.code_acc : '0;
    assign o_reply.code_present = w_tk.code_seen;
    assign o_reply.pasv_valid   = w_pasv;
    assign o_reply.pasv_addr    = w_pasv ? w_tk.addr_acc : '0;
    assign o_reply.pasv_port    = w_pasv ? w_tk.port_acc : '0;

    always_comb begin
        n_mode = r_mode;
        n_ps   = r_ps;
        o_end  = 1'b0;
        if (i_step) begin
            unique case (r_mode)
                MODE_MULTI: begin
                    if (w_lf) begin
                        n_ps   = PARSE_CLEAR;
                        n_mode = MODE_START;
                    end else begin
                        n_ps = w_tk;
                    end
                end
                MODE_SINGLE: begin
                    if (w_lf) begin
                        o_end  = 1'b1;
                        n_ps   = PARSE_CLEAR;
                        n_mode = MODE_START;
                    end else begin
                        n_ps = w_tk;
                    end
                end
                default: begin
                    n_ps = w_tk;
                    if (w_lf) begin
                        o_end  = 1'b1;
                        n_ps   = PARSE_CLEAR;
                        n_mode = MODE_START;
                    end else if (i_byte == CHR_SPACE) begin
                        n_mode = MODE_SINGLE;
                    end else if (i_byte == CHR_DASH) begin
                        n_mode = MODE_MULTI;
                    end else begin
                        n_mode = MODE_START;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_ps   <= PARSE_CLEAR;
        end else begin
            r_mode <= n_mode;
            r_ps   <= n_ps;
        end
    end

endmodule

// ===== rtl/ftp_reply_parser_unit.sv =====
// FTP reply parser top level: input register, parser core, result register.
// The ending newline passes the input register, the core, then the result register.
// Throughput: one byte per cycle while no result waits on a stalled result channel.
// Back-pressure on the result channel stalls the byte stage only while a result waits.
// Reset: synchronous active-low i_rst_n clears both valid flags and all parser state.
// Depends on frp_pkg, frp_byte_if, frp_reply_if, frp_core and the macros header.
`include "ftp_reply_parser_unit_macros.svh"

module ftp_reply_parser_unit
    import frp_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    frp_byte_if.sink    i_rx,
    frp_reply_if.source o_reply
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_reply     r_out;
    logic       w_advance;
    logic       w_end;
    t_reply     w_reply;

    assign w_advance = !r_out_valid || o_reply.ready;
    assign i_rx.ready = !r_in_valid || w_advance;

    frp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && w_advance),
        .i_byte  (r_in_byte),
        .o_end   (w_end),
        .o_reply (w_reply)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (w_advance) begin
                r_out_valid <= w_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_end) begin
            r_out <= w_reply;
        end
    end

    assign o_reply.valid        = r_out_valid;
    assign o_reply.reply_code   = r_out.reply_code;
    assign o_reply.code_present = r_out.code_present;
    assign o_reply.pasv_valid   = r_out.pasv_valid;
    assign o_reply.pasv_addr    = r_out.pasv_addr;
    assign o_reply.pasv_port    = r_out.pasv_port;

    `FRP_ASSERT_NXT(a_in_capture, i_clk, i_rst_n, i_rx.valid && i_rx.ready, r_in_valid, "accepted byte not held in input register")
    `FRP_ASSERT_IMP(a_pasv_code, i_clk, i_rst_n, r_out_valid && r_out.pasv_valid, r_out.code_present && (r_out.reply_code == CODE_PASV), "address reported without a 227 code")
    `FRP_ASSERT_IMP(a_no_code_zero, i_clk, i_rst_n, r_out_valid && !r_out.code_present, (r_out.reply_code == '0) && !r_out.pasv_valid, "code value without a code digit")
    `FRP_ASSERT_IMP(a_code_range, i_clk, i_rst_n, r_out_valid, r_out.reply_code <= CODE_MAX, "reply code above saturation limit")
    `FRP_ASSERT_IMP(a_addr_clear, i_clk, i_rst_n, r_out_valid && !r_out.pasv_valid, (r_out.pasv_addr == '0) && (r_out.pasv_port == '0), "address fields set without a parsed group")

endmodule

// ===== dv/frp_reply_check_pkg.sv =====
`timescale 1ns / 1ps
// Reply tracker for the FTP reply parser bench: predicts each reply from the request bytes
// and checks the replies that the parser returns. Depends on frp_pkg.
package frp_reply_check_pkg;
    import frp_pkg::*;

    class ftp_reply_tracker;
        t_mode  mode;
        t_parse pst;
        t_reply expected_replies[$];
        int     mismatches;
        int     replies_seen;
        int     pasv_seen;

        function new();
            mismatches   = 0;
            replies_seen = 0;
            pasv_seen    = 0;
            clear_reply();
        endfunction

        function void clear_reply();
            mode = MODE_START;
            pst  = PARSE_CLEAR;
        endfunction

        function bit blank_byte(logic [7:0] b);
            case (b)
                CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF, CHR_VT, CHR_FF: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void store_number();
            if (pst.number_index < ADDR_COUNT) begin
                pst.addr_acc = {pst.addr_acc[23:0], pst.number_acc};
            end else begin
                pst.port_acc = {pst.port_acc[7:0], pst.number_acc};
            end
        endfunction

        function void take_byte(logic [7:0] b);
            bit          digit;
            bit          started;
            int unsigned d;
            int unsigned v;
            digit   = (b >= CHR_ZERO) && (b <= CHR_NINE);
            d       = digit ? int'(b - CHR_ZERO) : 0;
            started = pst.code_seen || pst.code_closed;
            if (!pst.code_closed) begin
                if (digit) begin
                    v = pst.code_acc * 10 + d;
                    pst.code_acc  = (v > CODE_MAX) ? CODE_MAX : v[9:0];
                    pst.code_seen = 1'b1;
                end else begin
                    pst.code_closed = 1'b1;
                end
            end
            if (!pst.paren_seen) begin
                if (b == CHR_LPAREN) begin
                    pst.paren_seen   = 1'b1;
                    pst.number_index = started ? '0 : IDX_FAIL;
                    pst.number_acc   = '0;
                    pst.num_digit    = 1'b0;
                end
            end else if (pst.number_index <= IDX_LAST) begin
                if (digit) begin
                    v = pst.number_acc * 10 + d;
                    pst.number_acc = (v > NUM_MAX) ? NUM_MAX : v[7:0];
                    pst.num_digit  = 1'b1;
                end else if (!pst.num_digit) begin
                    if (!blank_byte(b)) pst.number_index = IDX_FAIL;
                end else if (pst.number_index == IDX_LAST) begin
                    store_number();
                    pst.number_index = IDX_DONE;
                end else if (b == CHR_COMMA) begin
                    store_number();
                    pst.number_index++;
                    pst.number_acc = '0;
                    pst.num_digit  = 1'b0;
                end else begin
                    pst.number_index = IDX_FAIL;
                end
            end
        endfunction

        function void finish_reply();
            t_reply r;
            bit     ok;
            // close a sixth number still open at the end of the reply
            if (pst.paren_seen && pst.number_index == IDX_LAST && pst.num_digit) begin
                store_number();
                pst.number_index = IDX_DONE;
            end
            ok = pst.code_seen && pst.code_acc == CODE_PASV && pst.paren_seen &&
                 pst.number_index == IDX_DONE;
            r.reply_code   = pst.code_seen ? pst.code_acc : '0;
            r.code_present = pst.code_seen;
            r.pasv_valid   = ok;
            r.pasv_addr    = ok ? pst.addr_acc : '0;
            r.pasv_port    = ok ? pst.port_acc : '0;
            expected_replies.push_back(r);
            if (ok) pasv_seen++;
            clear_reply();
        endfunction

        function void note_byte(logic [7:0] b);
            if (mode == MODE_MULTI) begin
                if (b == CHR_LF) begin
                    clear_reply();
                end else begin
                    take_byte(b);
                end
            end else begin
                take_byte(b);
                if (b == CHR_LF) begin
                    finish_reply();
                end else if (mode != MODE_SINGLE) begin
                    if (b == CHR_SPACE) begin
                        mode = MODE_SINGLE;
                    end else if (b == CHR_DASH) begin
                        mode = MODE_MULTI;
                    end else begin
                        mode = MODE_START;
                    end
                end
            end
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: reply_code %0d", got.reply_code);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.reply_code !== want.reply_code) begin
                $error("reply_code: expected %0d, actual %0d", want.reply_code, got.reply_code);
                mismatches++;
            end
            if (got.code_present !== want.code_present) begin
                $error("code_present: expected %0d, actual %0d",
                       want.code_present, got.code_present);
                mismatches++;
            end
            if (got.pasv_valid !== want.pasv_valid) begin
                $error("pasv_valid: expected %0d, actual %0d", want.pasv_valid, got.pasv_valid);
                mismatches++;
            end
            if (got.pasv_addr !== want.pasv_addr) begin
                $error("pasv_addr: expected %h, actual %h", want.pasv_addr, got.pasv_addr);
                mismatches++;
            end
            if (got.pasv_port !== want.pasv_port) begin
                $error("pasv_port: expected %0d, actual %0d", want.pasv_port, got.pasv_port);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_ftp_reply_parser_unit.sv =====
`timescale 1ns / 1ps
// Bench for ftp_reply_parser_unit: streams reply text, directed then random, through the
// byte channel and checks each parsed reply. Depends on frp_pkg, frp_reply_check_pkg and the RTL.
module tb_ftp_reply_parser_unit;
    import frp_pkg::*;
    import frp_reply_check_pkg::*;

    localparam logic [7:0] CHR_RPAREN  = 8'h29;
    localparam int         STALL_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 20;
    localparam int         HOLD_CYCLES = 300;
    localparam int         RANDOM_BYTES = 1350;

    logic i_clk = 1'b0;
    logic i_rst_n;

    frp_byte_if  u_rx ();
    frp_reply_if u_reply ();

    ftp_reply_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (u_rx),
        .o_reply (u_reply)
    );

    ftp_reply_tracker tracker;
    logic [7:0]       rx_stream[$];
    int               bytes_taken = 0;
    int               stall_cycles = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit steady_phase();
        return bytes_taken >= 300 && bytes_taken < 600;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
    endfunction

    function automatic void put_num(int unsigned n);
        put_text($sformatf("%0d", n));
    endfunction

    function automatic int unsigned pick_code();
        case ($urandom_range(0, 5))
            0, 1, 2: return CODE_PASV;
            3:       return $urandom_range(100, 599);
            4:       return $urandom_range(1000, 99999);
            default: return $urandom_range(0, 9);
        endcase
    endfunction

    function automatic void put_filler();
        string words[6] = '{"", " ok", "Entering Passive Mode ", "Service ready ",
                            "=h1,h2", " x-y "};
        put_text(words[$urandom_range(0, 5)]);
    endfunction

    function automatic void put_address();
        logic [7:0] blanks[5] = '{CHR_SPACE, CHR_TAB, CHR_CR, CHR_VT, CHR_FF};
        rx_stream.push_back(CHR_LPAREN);
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 7) == 0) rx_stream.push_back(blanks[$urandom_range(0, 4)]);
            if ($urandom_range(0, 19) == 0) rx_stream.push_back(CHR_DASH);
            put_num($urandom_range(0, 11) == 0 ? $urandom_range(256, 4000)
                                               : $urandom_range(0, 255));
            if (i < 5) rx_stream.push_back(CHR_COMMA);
        end
        if ($urandom_range(0, 5) != 0) rx_stream.push_back(CHR_RPAREN);
    endfunction

    function automatic void put_reply();
        int kind;
        int first;
        kind  = $urandom_range(0, 99);
        first = rx_stream.size();
        if (kind >= 80) begin
            repeat ($urandom_range(1, 10)) rx_stream.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) rx_stream.push_back(CHR_LF);
            return;
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
            put_num(pick_code());
            rx_stream.push_back(CHR_DASH);
            put_filler();
            if ($urandom_range(0, 3) == 0) put_address();
            rx_stream.push_back(CHR_LF);
        end
        if ($urandom_range(0, 15) != 0) put_num(pick_code());
        if ($urandom_range(0, 7) != 0) rx_stream.push_back(CHR_SPACE);
        put_filler();
        if (kind < 55) put_address();
        put_filler();
        if ($urandom_range(0, 1) == 1) rx_stream.push_back(CHR_CR);
        rx_stream.push_back(CHR_LF);
        // corrupt one byte, keep the closing newline
        if ($urandom_range(0, 9) == 0) begin
            rx_stream[$urandom_range(first, rx_stream.size() - 2)] = 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic offer(input logic [7:0] b);
        while (!steady_phase() && $urandom_range(0, 99) < 15) begin
            u_rx.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_rx.valid   <= 1'b1;
        u_rx.rx_byte <= b;
        @(posedge i_clk);
        while (!u_rx.ready) @(posedge i_clk);
        tracker.note_byte(b);
        bytes_taken++;
    endtask

    task automatic wait_drained();
        u_rx.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_replies.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_reply.ready <= 1'b0;
        end else begin
            if (u_reply.valid && u_reply.ready) begin
                tracker.check_reply({u_reply.reply_code, u_reply.code_present,
                                     u_reply.pasv_valid, u_reply.pasv_addr, u_reply.pasv_port});
            end
            if (hold_left > 0) begin
                hold_left--;
                u_reply.ready <= 1'b0;
            end else if (!hold_done && tracker.replies_seen == 10) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                u_reply.ready <= 1'b0;
            end else begin
                u_reply.ready <= steady_phase() || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !((u_rx.valid && u_rx.ready) || (u_reply.valid && u_reply.ready))) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("status: fail");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    initial begin
        int drain_at;
        tracker = new();
        i_rst_n       <= 1'b0;
        u_rx.valid    <= 1'b0;
        u_rx.rx_byte  <= '0;

        // multi-line restart, open sixth number, parenthesis first
        put_text("227-x\n");
        put_text("227 (1,2,3,4,5,6\n");
        put_text("(\n");
        while (rx_stream.size() < RANDOM_BYTES) put_reply();
        drain_at = rx_stream.size() * 3 / 4;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rx_stream[k]) begin
            if (k == drain_at) wait_drained();
            offer(rx_stream[k]);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d request bytes and %0d replies, %0d with a passive address",
                 bytes_taken, tracker.replies_seen, tracker.pasv_seen);
        if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
